>>> hw/rtl/lsnu_pkg.sv
// shared types, constants and codes of the level-set node update block
`timescale 1ns / 1ps
`default_nettype none
package lsnu_pkg;

  // configuration register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_STEP = 1'b1;

  // update mode codes
  localparam logic MODE_ADVECT = 1'b0;
  localparam logic MODE_REINIT = 1'b1;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // fixed constants of the arithmetic
  localparam logic [30:0] SLOPE_MAX    = 31'h7FFF_FFFF;
  localparam logic [24:0] EDGE_ONES    = 25'h1FF_FFFF;
  localparam logic [31:0] FALLBACK_DT  = 32'd2147;
  localparam logic [30:0] ONE_Q16      = 31'd65536;
  localparam logic [34:0] MAG_LIMIT    = 35'h4_0000_0000;

  // back end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_ROOT,
    ST_DIV,
    ST_ACC,
    ST_MUL,
    ST_HI,
    ST_LO,
    ST_FIN
  } lsnu_state_t;

  // one classified neighbour record
  typedef struct packed {
    logic [23:0] dx;
    logic [23:0] dy;
    logic [23:0] dz;
    logic [31:0] dphi;
    logic [31:0] phi;
    logic [31:0] speed;
    logic        nonneg;
    logic        last;
  } lsnu_rec_t;

  // configuration seen by the back end
  typedef struct packed {
    logic        mode;
    logic [30:0] step_time;
  } lsnu_cfg_t;

  // queue status
  typedef struct packed {
    logic empty;
    logic full;
  } lsnu_qstat_t;

endpackage
`default_nettype wire

>>> hw/rtl/levelset_node_update_core.sv
// top level of the level-set node update block
//
// Input channel: one neighbour record of a mesh node per transfer, taken on
// push while full is low. The record flagged last_nbr closes the node and
// produces one result; other records only update the running max slope and
// the shortest edge.
// Result channel: the oldest result stands on the out_ ports while empty is
// low and leaves on pop. A single output register holds it.
// A two-entry queue parts the input side from the back end, so records are
// taken while the back end works or the result waits.
// Each record passes through the back end in turn: it is drawn from the queue,
// the squared length is summed over dx, dy and dz, a bitwise square root gives
// the edge length, a bit-serial slope divider (cut short for a zero length
// edge) gives the slope, and slope and edge are accumulated. A last record then
// runs the update: a multiply (advect: also high and low halves by the speed).
// Reset clears the queue, the accumulators and the result valid flag.
// When the receiver stalls, the back end holds its finished result and then
// full rises once the queue fills. Configuration (update_mode, step_time) is
// to be written by the user only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module levelset_node_update_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [23:0] in_center_x,
  input  wire logic signed [23:0] in_center_y,
  input  wire logic signed [23:0] in_center_z,
  input  wire logic signed [31:0] in_center_phi,
  input  wire logic signed [31:0] in_center_speed,
  input  wire logic               in_ref_nonneg,
  input  wire logic signed [23:0] in_nbr_x,
  input  wire logic signed [23:0] in_nbr_y,
  input  wire logic signed [23:0] in_nbr_z,
  input  wire logic signed [31:0] in_nbr_phi,
  input  wire logic               in_last_nbr,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      out_new_phi,
  output logic        [30:0]      out_grad_estimate,
  output logic        [24:0]      out_shortest_edge,
  input  wire logic               cfg_wen,
  input  wire logic               cfg_index,
  input  wire logic [30:0]        cfg_data
);
  import lsnu_pkg::*;

  lsnu_cfg_t   cfg_r;
  lsnu_qstat_t q_stat;
  lsnu_rec_t   f_rec, b_rec;
  logic        f_push, b_pop, out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MODE: cfg_r.mode      <= cfg_data[0];
        REG_STEP: cfg_r.step_time <= cfg_data;
        default:  ;
      endcase
    end
  end

  lsnu_front u_front (
    .in_valid     (push),
    .q_full       (q_stat.full),
    .center_x     (in_center_x),
    .center_y     (in_center_y),
    .center_z     (in_center_z),
    .center_phi   (in_center_phi),
    .center_speed (in_center_speed),
    .ref_nonneg   (in_ref_nonneg),
    .nbr_x        (in_nbr_x),
    .nbr_y        (in_nbr_y),
    .nbr_z        (in_nbr_z),
    .nbr_phi      (in_nbr_phi),
    .last_nbr     (in_last_nbr),
    .q_push       (f_push),
    .q_rec        (f_rec)
  );

  lsnu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (f_push),
    .wr_rec (f_rec),
    .pop    (b_pop),
    .rd_rec (b_rec),
    .stat   (q_stat)
  );

  lsnu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_stat      (q_stat),
    .q_rec       (b_rec),
    .q_pop       (b_pop),
    .out_pop     (pop),
    .out_valid   (out_valid),
    .out_new_phi (out_new_phi),
    .out_grad    (out_grad_estimate),
    .out_edge    (out_shortest_edge)
  );

  assign full  = q_stat.full;
  assign empty = !out_valid;

  // queue cannot be empty and full at once
  a_qstat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.empty && q_stat.full))
    else $error("queue status inconsistent");

  // a waiting result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !pop) |=> out_valid)
    else $error("result lost while stalled");

  // back end only draws from a non-empty queue
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    b_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

endmodule
`default_nettype wire

>>> hw/rtl/lsnu_front.sv
// front end: accepts neighbour records and reduces them to magnitudes
`timescale 1ns / 1ps
`default_nettype none
module lsnu_front (
  input  wire logic                    in_valid,
  input  wire logic                    q_full,
  input  wire logic signed [23:0]      center_x,
  input  wire logic signed [23:0]      center_y,
  input  wire logic signed [23:0]      center_z,
  input  wire logic signed [31:0]      center_phi,
  input  wire logic signed [31:0]      center_speed,
  input  wire logic                    ref_nonneg,
  input  wire logic signed [23:0]      nbr_x,
  input  wire logic signed [23:0]      nbr_y,
  input  wire logic signed [23:0]      nbr_z,
  input  wire logic signed [31:0]      nbr_phi,
  input  wire logic                    last_nbr,
  output logic                         q_push,
  output lsnu_pkg::lsnu_rec_t          q_rec
);
  import lsnu_pkg::*;

  logic signed [24:0] dx_s, dy_s, dz_s;
  logic signed [32:0] dp_s;
  logic        [24:0] dx_a, dy_a, dz_a;
  logic        [32:0] dp_a;

  // signed differences, neighbour minus centre
  assign dx_s = 25'(nbr_x) - 25'(center_x);
  assign dy_s = 25'(nbr_y) - 25'(center_y);
  assign dz_s = 25'(nbr_z) - 25'(center_z);
  assign dp_s = 33'(nbr_phi) - 33'(center_phi);

  // magnitudes, which always fit the narrower fields
  assign dx_a = dx_s[24] ? 25'(-dx_s) : 25'(dx_s);
  assign dy_a = dy_s[24] ? 25'(-dy_s) : 25'(dy_s);
  assign dz_a = dz_s[24] ? 25'(-dz_s) : 25'(dz_s);
  assign dp_a = dp_s[32] ? 33'(-dp_s) : 33'(dp_s);

  // record towards the queue
  always_comb begin
    q_rec.dx     = dx_a[23:0];
    q_rec.dy     = dy_a[23:0];
    q_rec.dz     = dz_a[23:0];
    q_rec.dphi   = dp_a[31:0];
    q_rec.phi    = center_phi;
    q_rec.speed  = center_speed;
    q_rec.nonneg = ref_nonneg;
    q_rec.last   = last_nbr;
  end

  assign q_push = in_valid && !q_full;

endmodule
`default_nettype wire

>>> hw/rtl/lsnu_queue.sv
// short record queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module lsnu_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire lsnu_pkg::lsnu_rec_t wr_rec,
  input  wire logic                pop,
  output lsnu_pkg::lsnu_rec_t      rd_rec,
  output lsnu_pkg::lsnu_qstat_t    stat
);
  import lsnu_pkg::*;

  lsnu_rec_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_rec     = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lsnu_back.sv
// back end: edge length, slope, accumulation and final update
`timescale 1ns / 1ps
`default_nettype none
module lsnu_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lsnu_pkg::lsnu_cfg_t   cfg,
  input  wire lsnu_pkg::lsnu_qstat_t q_stat,
  input  wire lsnu_pkg::lsnu_rec_t   q_rec,
  output logic                       q_pop,
  input  wire logic                  out_pop,
  output logic                       out_valid,
  output logic signed [31:0]         out_new_phi,
  output logic        [30:0]         out_grad,
  output logic        [24:0]         out_edge
);
  import lsnu_pkg::*;

  lsnu_state_t state_r, state_nxt;

  lsnu_rec_t   rec_r;
  logic [49:0] sum_r, v_r, res_r, bit_r;
  logic [5:0]  cnt_r;
  logic [24:0] len_r, rem_r;
  logic [47:0] num_r, quo_r;
  logic [30:0] max_slope_r;
  logic [24:0] min_edge_r;
  logic [63:0] prod_r, hi_r, lo_r;
  logic        out_valid_r;
  logic [31:0] out_phi_r;
  logic [30:0] out_grad_r;
  logic [24:0] out_edge_r;

  logic        out_free;
  logic [23:0] sq_sel;
  logic [47:0] sq_w;
  logic [49:0] sum_w, rb_w, res_step;
  logic        root_ge;
  logic [25:0] dt_w;
  logic        div_ge;
  logic [25:0] rem_w;
  logic [30:0] slope_w, slope_acc, at_w;
  logic [24:0] edge_acc;
  logic        term_neg;
  logic [31:0] opa, opb, s_w;
  logic [63:0] mag_w;
  logic [34:0] mag_c;
  logic [38:0] delta_w;
  logic signed [41:0] phi_e, amt, res_w;
  logic        plus;
  logic [31:0] sat_w;

  assign out_free = !out_valid_r || out_pop;

  // squares of the coordinate differences, one per cycle
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_sel = rec_r.dx;
      2'd1:    sq_sel = rec_r.dy;
      default: sq_sel = rec_r.dz;
    endcase
  end
  assign sq_w  = sq_sel * sq_sel;
  assign sum_w = sum_r + 50'(sq_w);

  // one step of the bitwise square root
  assign rb_w     = res_r + bit_r;
  assign root_ge  = (v_r >= rb_w);
  assign res_step = root_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  // one step of the restoring divider
  assign dt_w   = {rem_r, num_r[47]};
  assign div_ge = (dt_w >= {1'b0, len_r});
  assign rem_w  = div_ge ? (dt_w - {1'b0, len_r}) : dt_w;

  // accumulation of slope and edge
  assign slope_w   = (|quo_r[47:31]) ? SLOPE_MAX : quo_r[30:0];
  assign slope_acc = ((len_r != '0) && (slope_w > max_slope_r)) ? slope_w : max_slope_r;
  assign edge_acc  = (len_r < min_edge_r) ? len_r : min_edge_r;

  // multiplier operands
  assign term_neg = (max_slope_r > ONE_Q16);
  assign at_w     = term_neg ? (max_slope_r - ONE_Q16) : (ONE_Q16 - max_slope_r);
  always_comb begin
    if (cfg.mode == MODE_ADVECT) begin
      opa = {1'b0, cfg.step_time};
      opb = {1'b0, max_slope_r};
    end else begin
      opa = (min_edge_r != '0) ? {7'b0, min_edge_r} : FALLBACK_DT;
      opb = {1'b0, at_w};
    end
  end
  assign s_w = rec_r.speed[31] ? (~rec_r.speed + 32'd1) : rec_r.speed;

  // final sum and saturation
  assign mag_w   = hi_r + {32'b0, lo_r[63:32]};
  assign mag_c   = (mag_w > 64'(MAG_LIMIT)) ? MAG_LIMIT : mag_w[34:0];
  assign delta_w = (min_edge_r != '0) ? prod_r[55:17] : {7'b0, prod_r[63:32]};
  assign phi_e   = 42'(signed'(rec_r.phi));
  always_comb begin
    if (cfg.mode == MODE_ADVECT) begin
      amt  = 42'({7'b0, mag_c});
      plus = rec_r.speed[31];
    end else begin
      amt  = 42'({3'b0, delta_w});
      plus = (rec_r.nonneg == !term_neg);
    end
  end
  assign res_w = plus ? (phi_e + amt) : (phi_e - amt);
  always_comb begin
    if (res_w > 42'sd2147483647) begin
      sat_w = 32'h7FFF_FFFF;
    end else if (res_w < -42'sd2147483648) begin
      sat_w = 32'h8000_0000;
    end else begin
      sat_w = res_w[31:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_stat.empty) state_nxt = ST_SQR;
      ST_SQR:  if (cnt_r == 6'd2) state_nxt = ST_ROOT;
      ST_ROOT: if (bit_r == 50'd1) state_nxt = ST_DIV;
      ST_DIV:  if (len_r == '0 || cnt_r == 6'd47) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = rec_r.last ? ST_MUL : ST_IDLE;
      ST_MUL:  state_nxt = (cfg.mode == MODE_ADVECT) ? ST_HI : ST_FIN;
      ST_HI:   state_nxt = ST_LO;
      ST_LO:   state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop = 1'b0;
    case (state_r)
      ST_IDLE: q_pop = !q_stat.empty;
      default: q_pop = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_slope_r <= '0;
      min_edge_r  <= EDGE_ONES;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_ACC) begin
        max_slope_r <= slope_acc;
        min_edge_r  <= edge_acc;
      end
      if (state_r == ST_FIN && out_free) begin
        max_slope_r <= '0;
        min_edge_r  <= EDGE_ONES;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        rec_r <= q_rec;
        sum_r <= '0;
        cnt_r <= '0;
      end
      ST_SQR: begin
        sum_r <= sum_w;
        cnt_r <= cnt_r + 6'd1;
        v_r   <= sum_w;
        res_r <= '0;
        bit_r <= 50'd1 << 48;
      end
      ST_ROOT: begin
        if (root_ge) v_r <= v_r - rb_w;
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        len_r <= res_step[24:0];
        rem_r <= '0;
        num_r <= {rec_r.dphi, 16'b0};
        quo_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_w[24:0];
        num_r <= num_r << 1;
        quo_r <= {quo_r[46:0], div_ge};
        cnt_r <= cnt_r + 6'd1;
      end
      ST_MUL: prod_r <= opa * opb;
      ST_HI:  hi_r <= {32'b0, prod_r[63:32]} * {32'b0, s_w};
      ST_LO:  lo_r <= {32'b0, prod_r[31:0]} * {32'b0, s_w};
      ST_FIN: begin
        if (out_free) begin
          out_phi_r  <= sat_w;
          out_grad_r <= max_slope_r;
          out_edge_r <= min_edge_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_new_phi = out_phi_r;
  assign out_grad    = out_grad_r;
  assign out_edge    = out_edge_r;

endmodule
`default_nettype wire
